### hdl/edsr_pkg.sv
// ============================================================================
// edsr_pkg: shared types and constants for the DER-to-raw signature converter
// Phase codes of the parser, widths of the stream fields, the result record.
// ============================================================================
package edsr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;

    localparam logic [BYTE_W-1:0] LEAD_ZERO = 8'h00;

    typedef enum logic [3:0] {
        PH_SEQ_TAG   = 4'd0,
        PH_TOTAL_LEN = 4'd1,
        PH_R_TAG     = 4'd2,
        PH_R_LEN     = 4'd3,
        PH_R_FIRST   = 4'd4,
        PH_R_DATA    = 4'd5,
        PH_S_TAG     = 4'd6,
        PH_S_LEN     = 4'd7,
        PH_S_FIRST   = 4'd8,
        PH_S_DATA    = 4'd9,
        PH_DONE      = 4'd10
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               has_data;
        logic               last;
        logic [COUNT_W-1:0] length;
    } result_t;

endpackage

### hdl/edsr_if.sv
// ============================================================================
// edsr_if: stream channels of the DER-to-raw signature converter
// Input channel carries DER bytes, output channel carries raw r/s bytes.
// ============================================================================
interface edsr_in_if
    import edsr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_start;

    modport source (output valid, output in_byte, output in_start, input ready);
    modport sink   (input valid, input in_byte, input in_start, output ready);
endinterface

interface edsr_out_if
    import edsr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_has_data;
    logic               out_last;
    logic [COUNT_W-1:0] out_length;

    modport source (output valid, output out_byte, output out_has_data,
                    output out_last, output out_length, input ready);
    modport sink   (input valid, input out_byte, input out_has_data,
                    input out_last, input out_length, output ready);
endinterface

### hdl/edsr_parse.sv
// ============================================================================
// edsr_parse: DER signature parser
// Tracks the phase, the bytes left in the current integer and the emitted
// count; gives at most one result per accepted byte.
// ============================================================================
module edsr_parse
    import edsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_start,
    output logic              emit,
    output result_t           result
);

    phase_t             phase_reg,  phase_next;
    logic [BYTE_W-1:0]  left_reg,   left_next;
    logic [COUNT_W-1:0] count_reg,  count_next;

    logic [BYTE_W-1:0]  left_dec;
    logic [COUNT_W-1:0] count_inc;
    logic               ends;
    logic               drop;
    logic               is_first;

    assign left_dec  = left_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign ends      = (left_dec == '0);
    assign is_first  = (phase_reg == PH_R_FIRST) || (phase_reg == PH_S_FIRST);
    assign drop      = is_first && (in_byte == LEAD_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEQ_TAG;
            left_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        count_next = count_reg;
        emit       = 1'b0;
        result     = '0;

        if (in_start || (phase_reg == PH_SEQ_TAG))
        begin
            count_next = '0;
            left_next  = '0;
            phase_next = PH_TOTAL_LEN;
        end
        else
        begin
            case (phase_reg)
                PH_TOTAL_LEN: phase_next = PH_R_TAG;
                PH_R_TAG:     phase_next = PH_R_LEN;
                PH_R_LEN:
                begin
                    left_next  = in_byte;
                    phase_next = (in_byte == '0) ? PH_S_TAG : PH_R_FIRST;
                end
                PH_R_FIRST, PH_R_DATA:
                begin
                    left_next  = left_dec;
                    phase_next = ends ? PH_S_TAG : PH_R_DATA;
                    if (!drop)
                    begin
                        count_next      = count_inc;
                        emit            = 1'b1;
                        result.data     = in_byte;
                        result.has_data = 1'b1;
                    end
                end
                PH_S_TAG:     phase_next = PH_S_LEN;
                PH_S_LEN:
                begin
                    left_next = in_byte;
                    if (in_byte == '0)
                    begin
                        phase_next    = PH_DONE;
                        emit          = 1'b1;
                        result.last   = 1'b1;
                        result.length = count_reg;
                    end
                    else
                    begin
                        phase_next = PH_S_FIRST;
                    end
                end
                PH_S_FIRST, PH_S_DATA:
                begin
                    left_next  = left_dec;
                    phase_next = ends ? PH_DONE : PH_S_DATA;
                    if (!drop)
                    begin
                        count_next      = count_inc;
                        emit            = 1'b1;
                        result.data     = in_byte;
                        result.has_data = 1'b1;
                        result.last     = ends;
                        result.length   = ends ? count_inc : '0;
                    end
                    else if (ends)
                    begin
                        emit          = 1'b1;
                        result.last   = 1'b1;
                        result.length = count_reg;
                    end
                end
                default:      phase_next = PH_DONE;
            endcase
        end
    end

endmodule

### hdl/ecdsa_der_signature_to_raw.sv
// ============================================================================
// ecdsa_der_signature_to_raw: DER-encoded ECDSA signature to raw r||s bytes
//
//   channel | dir | fields                                  | beat
//   din     | in  | in_byte[7:0], in_start                  | one DER byte
//   dout    | out | out_byte[7:0], out_has_data, out_last,  | zero or one
//           |     | out_length[8:0]                         | per input beat
//
// One input beat per cycle while ready; its result, if any, appears in the
// output register the next cycle. The output register frees din.ready whenever
// it is empty or being drained, so a stalled dout stops din only while full.
// rst_n clears the parser phase, counters and output valid.
// ============================================================================
module ecdsa_der_signature_to_raw
    import edsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    edsr_in_if.sink    din,
    edsr_out_if.source dout
);

    logic    accept;
    logic    emit;
    result_t result;

    logic    out_valid_reg;
    result_t out_reg;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    edsr_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (din.in_byte),
        .in_start (din.in_start),
        .emit     (emit),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg <= result;
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.out_byte     = out_reg.data;
    assign dout.out_has_data = out_reg.has_data;
    assign dout.out_last     = out_reg.last;
    assign dout.out_length   = out_reg.length;

endmodule
